FILE: src/stmf_pkg.sv
package stmf_pkg;

   localparam int SAMPLE_W = 24;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Commands from the controller to the datapath, at most one high per cycle.
   typedef struct packed {
      logic load;
      logic scan;
      logic trim;
      logic prep;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_all;
      logic rd_busy;
      logic div_done;
   } status_type;

endpackage

FILE: src/stmf_req_if.sv
interface stmf_req_if;
   logic                   valid;
   logic                   ready;
   stmf_pkg::sample_type   sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

FILE: src/stmf_rsp_if.sv
interface stmf_rsp_if;
   logic                   valid;
   logic                   ready;
   stmf_pkg::sample_type   filtered;

   modport source (output valid, output filtered, input ready);
   modport sink (input valid, input filtered, output ready);
endinterface

FILE: src/stmf_ram.sv
module stmf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/stmf_datapath.sv
module stmf_datapath #(
   parameter int WINDOW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stmf_pkg::cmd_type     cmd,
   output stmf_pkg::status_type  status,
   input  stmf_pkg::sample_type  req_sample,
   output stmf_pkg::sample_type  rsp_filtered
);

   localparam int SW     = stmf_pkg::SAMPLE_W;
   localparam int ADDR_W = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = SW + $clog2(WINDOW);
   localparam int MAG_W  = SUM_W + 2;
   localparam int DEN_W  = CNT_W + 1;
   localparam int DIVC_W = $clog2(MAG_W + 1);

   logic [ADDR_W-1:0]       wp_ff, wp_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   logic                    rvalid_ff, rvalid_in;
   logic                    first_ff, first_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SW-1:0]    max_ff, max_in;
   logic signed [SW-1:0]    min_ff, min_in;
   logic signed [SUM_W-1:0] tsum_ff, tsum_in;
   logic [CNT_W-1:0]        den_ff, den_in;
   logic [DEN_W-1:0]        den2_ff, den2_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [MAG_W-1:0]        quo_ff, quo_in;
   logic                    neg_ff, neg_in;
   logic [DIVC_W-1:0]       divc_ff, divc_in;
   stmf_pkg::sample_type    filtered_ff, filtered_in;

   logic [SW-1:0]           rd_data;
   logic signed [SW-1:0]    rd_val;
   logic signed [SUM_W-1:0] rd_ext;
   logic signed [MAG_W-1:0] num_val;
   logic [DEN_W:0]          shifted;
   logic [DEN_W+1:0]        diff;
   logic [SW-1:0]           quo_low;

   stmf_ram #(
      .WIDTH (SW),
      .DEPTH (WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_val  = $signed(rd_data);
   assign rd_ext  = SUM_W'(rd_val);
   // Numerator of the rounded mean: twice the sum plus the divisor.
   assign num_val = (MAG_W'(tsum_ff) <<< 1) + MAG_W'($signed({1'b0, den_ff}));
   assign shifted = {rem_ff, quo_ff[MAG_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den2_ff};
   assign quo_low = quo_ff[SW-1:0];

   always_comb begin
      wp_in       = wp_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      rvalid_in   = cmd.scan;
      first_in    = first_ff;
      sum_in      = sum_ff;
      max_in      = max_ff;
      min_in      = min_ff;
      tsum_in     = tsum_ff;
      den_in      = den_ff;
      den2_in     = den2_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      neg_in      = neg_ff;
      divc_in     = divc_ff;
      filtered_in = filtered_ff;

      if (cmd.load) begin
         wp_in    = (wp_ff == ADDR_W'(WINDOW - 1)) ? '0 : wp_ff + 1'b1;
         count_in = (count_ff == CNT_W'(WINDOW)) ? count_ff : count_ff + 1'b1;
         idx_in   = '0;
         first_in = 1'b1;
      end

      if (cmd.scan) begin
         idx_in = idx_ff + 1'b1;
      end

      if (rvalid_ff) begin
         first_in = 1'b0;
         if (first_ff) begin
            sum_in = rd_ext;
            max_in = rd_val;
            min_in = rd_val;
         end else begin
            sum_in = sum_ff + rd_ext;
            if (rd_val > max_ff) begin
               max_in = rd_val;
            end
            if (rd_val < min_ff) begin
               min_in = rd_val;
            end
         end
      end

      // With all samples equal, dropping one maximum and one minimum leaves
      // the same rounded mean, so no separate case is needed.
      if (cmd.trim) begin
         if (count_ff <= CNT_W'(2)) begin
            tsum_in = sum_ff;
            den_in  = count_ff;
         end else begin
            tsum_in = sum_ff - SUM_W'(max_ff) - SUM_W'(min_ff);
            den_in  = count_ff - CNT_W'(2);
         end
      end

      if (cmd.prep) begin
         neg_in  = num_val[MAG_W-1];
         quo_in  = num_val[MAG_W-1] ? MAG_W'(-num_val) : MAG_W'(num_val);
         rem_in  = '0;
         den2_in = {den_ff, 1'b0};
         divc_in = '0;
      end

      if (cmd.div_step) begin
         divc_in = divc_ff + 1'b1;
         if (!diff[DEN_W+1]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[MAG_W-2:0], 1'b0};
         end
      end

      if (cmd.out_load) begin
         filtered_in = neg_ff ? $signed(-quo_low) : $signed(quo_low);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         count_ff  <= '0;
         idx_ff    <= '0;
         rvalid_ff <= 1'b0;
         first_ff  <= 1'b0;
         divc_ff   <= '0;
      end else begin
         wp_ff     <= wp_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         rvalid_ff <= rvalid_in;
         first_ff  <= first_in;
         divc_ff   <= divc_in;
      end
      sum_ff      <= sum_in;
      max_ff      <= max_in;
      min_ff      <= min_in;
      tsum_ff     <= tsum_in;
      den_ff      <= den_in;
      den2_ff     <= den2_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      filtered_ff <= filtered_in;
   end

   assign status.scan_all = (idx_ff == count_ff);
   assign status.rd_busy  = rvalid_ff;
   assign status.div_done = (divc_ff == DIVC_W'(MAG_W));
   assign rsp_filtered    = filtered_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW))
      else $error("valid count beyond window size");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (idx_ff < count_ff))
      else $error("window read beyond the valid samples");

   a_wp_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff < CNT_W'(WINDOW)) |-> (CNT_W'(wp_ff) == count_ff))
      else $error("write pointer out of step with fill count");
`endif

endmodule

FILE: src/stmf_ctrl.sv
module stmf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stmf_pkg::cmd_type    cmd,
   input  stmf_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TRIM,
      ST_PREP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid;
      cmd.scan     = (state_ff == ST_SCAN) && !status.scan_all;
      cmd.trim     = (state_ff == ST_TRIM);
      cmd.prep     = (state_ff == ST_PREP);
      cmd.div_step = (state_ff == ST_DIVIDE) && !status.div_done;
      cmd.out_load = (state_ff == ST_DONE) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A result loaded in the same cycle keeps the output valid.
         if (rsp_valid_ff && rsp_ready && !cmd.out_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // The last read returns in the cycle after it is issued.
               if (status.scan_all && !status.rd_busy) begin
                  state_ff <= ST_TRIM;
               end
            end
            ST_TRIM: begin
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (status.div_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_out_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> slot_free)
      else $error("result loaded over an item not yet taken");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_SCAN))
      else $error("accepted item did not start a window scan");

   a_no_step_after_done: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !status.div_done)
      else $error("divider stepped past its last bit");
`endif

endmodule

FILE: src/sliding_trimmed_mean_filter.sv
// Sliding-window trimmed mean over the last WINDOW signed 24-bit samples.
// Each accepted item is written into a window RAM, then the valid samples
// are read back one per cycle through the RAM's single read port to form
// the sum, maximum and minimum; from three samples on, one maximum and one
// minimum are dropped, and the mean plus one half, truncated toward zero,
// comes out of a restoring divider that retires one quotient bit per cycle.
// An item passes in turn through the scan, trim, divider setup, divide
// and output states, and no new item is taken before its result is loaded.
// A finished result waits in the output register while the next item is
// taken. The window starts empty after reset, and needs no clearing pass.
module sliding_trimmed_mean_filter #(
   parameter int WINDOW = 8
) (
   input  logic       clock,
   input  logic       reset,
   stmf_req_if.sink   req_chan,
   stmf_rsp_if.source rsp_chan
);

   stmf_pkg::cmd_type    cmd;
   stmf_pkg::status_type status;

   stmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   stmf_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_sample   (req_chan.sample),
      .rsp_filtered (rsp_chan.filtered)
   );

endmodule

FILE: verif/sliding_trimmed_mean_filter_tb.sv
module sliding_trimmed_mean_filter_tb;

   localparam int WINDOW       = 8;
   localparam int RANDOM_ITEMS = 900;
   localparam int QUIET_FROM   = 750;
   localparam int HOLD_AT      = 200;
   localparam int DRAIN_AT     = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 60;

   class trimmed_mean_scoreboard;
      stmf_pkg::sample_type window_samples[WINDOW];
      int                   sample_count;
      stmf_pkg::sample_type expected_filtered[$];
      int                   mismatches;

      function new();
         foreach (window_samples[i]) window_samples[i] = '0;
         sample_count = 0;
         mismatches   = 0;
      endfunction

      function int pending();
         return expected_filtered.size();
      endfunction

      // Shift the sample into the window and work out the trimmed mean.
      function void note_sample(stmf_pkg::sample_type s);
         longint total;
         longint mean;
         int     n;
         int     hi_at;
         int     lo_at;
         if (sample_count >= WINDOW) begin
            for (int i = 0; i + 1 < WINDOW; i++) window_samples[i] = window_samples[i+1];
            window_samples[WINDOW-1] = s;
         end else begin
            window_samples[sample_count] = s;
            sample_count++;
         end
         n     = sample_count;
         total = 0;
         for (int i = 0; i < n; i++) total += window_samples[i];
         hi_at = 0;
         lo_at = 0;
         // Strict comparisons keep the earliest entry among equal extremes.
         for (int i = 1; i < n; i++) begin
            if (window_samples[i] > window_samples[hi_at]) hi_at = i;
            if (window_samples[i] < window_samples[lo_at]) lo_at = i;
         end
         if (n > 2 && hi_at != lo_at) begin
            total -= window_samples[hi_at];
            total -= window_samples[lo_at];
            n -= 2;
         end
         mean = (2 * total + n) / (2 * n);
         expected_filtered.push_back(mean[stmf_pkg::SAMPLE_W-1:0]);
      endfunction

      function void check_filtered(stmf_pkg::sample_type actual);
         stmf_pkg::sample_type expected;
         if (expected_filtered.size() == 0) begin
            $error("filtered: expected nothing, actual %0d", actual);
            mismatches++;
         end else begin
            expected = expected_filtered.pop_front();
            if (actual !== expected) begin
               $error("filtered: expected %0d, actual %0d", expected, actual);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   bit   long_hold;

   stmf_req_if req_if ();
   stmf_rsp_if rsp_if ();

   trimmed_mean_scoreboard sb = new();

   int directed_values[] = '{
      -8388608, -8388608, -8388608, 8388607, 8388607, 0, -1, 1,
      5, 5, 5, 5, 5, 5, 5, 5,
      3, 3, -2, -2,
      8388607, -8388608, 8388607, -8388608
   };

   sliding_trimmed_mean_filter #(
      .WINDOW(WINDOW)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Offer one item and hold it until it is taken, then idle for the given gap if it is nonzero.
   task automatic send_sample(input stmf_pkg::sample_type s, input int gap);
      req_if.valid  <= 1'b1;
      req_if.sample <= s;
      do @(posedge clock); while (!req_if.ready);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) sb.note_sample(req_if.sample);
         if (rsp_if.valid && rsp_if.ready) sb.check_filtered(rsp_if.filtered);
      end
   end

   initial begin
      stmf_pkg::sample_type s;
      int                   gap;
      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.sample <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[i]) begin
         send_sample(stmf_pkg::sample_type'(directed_values[i]), 0);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         quiet = (i >= QUIET_FROM);
         if (i == HOLD_AT) long_hold = 1'b1;
         if (i == DRAIN_AT) begin
            req_if.valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 3))
                  0: s = {1'b1, {(stmf_pkg::SAMPLE_W-1){1'b0}}};
                  1: s = {1'b0, {(stmf_pkg::SAMPLE_W-1){1'b1}}};
                  2: s = '1;
                  default: s = '0;
               endcase
            end
            // Narrow values make ties among the extremes frequent.
            1, 2: s = stmf_pkg::sample_type'($urandom_range(0, 8))
                      - stmf_pkg::sample_type'(4);
            3: s = stmf_pkg::sample_type'($urandom_range(0, 2000))
                   - stmf_pkg::sample_type'(1000);
            default: s = stmf_pkg::sample_type'($urandom);
         endcase
         gap = 0;
         if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
         send_sample(s, gap);
      end
      req_if.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("sliding_trimmed_mean_filter_tb OK");
      end else begin
         $display("sliding_trimmed_mean_filter_tb NOT OK");
      end
      $finish;
   end

   initial begin
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold) begin
            // A long stall lets the block fill up and push back on its input.
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      #500000;
      $display("sliding_trimmed_mean_filter_tb NOT OK");
      $finish;
   end

endmodule
